[src/bmf_pkg.sv]
// ----------------------------------------------------------------------------
// bmf_pkg: shared definitions for the box mean filter
// Register indexes, reset values, pixel widths and default sizes.
// ----------------------------------------------------------------------------
package bmf_pkg;

  // Default sizes for the top-level parameters.
  localparam int DEF_MAX_WIDTH = 1024;
  localparam int DEF_MAX_HALF  = 3;

  // Pixel channel layout.
  localparam int PIX_W  = 8;
  localparam int NUM_CH = 3;

  // Configuration port layout.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;
  localparam int FW_W       = 11;
  localparam int FH_W       = 13;
  localparam int HALF_W     = 2;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_HALF     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COL_HALF     = 3'd3;

  // Register reset values.
  localparam logic [FW_W-1:0]   RST_FRAME_WIDTH  = 11'd640;
  localparam logic [FH_W-1:0]   RST_FRAME_HEIGHT = 13'd480;
  localparam logic [HALF_W-1:0] RST_ROW_HALF     = 2'd3;
  localparam logic [HALF_W-1:0] RST_COL_HALF     = 2'd3;

endpackage

[src/box_mean_filter.sv]
// ----------------------------------------------------------------------------
// box_mean_filter: streaming RGB box mean filter
// Stores recent rows in a ring of line buffers, sums the window of each
// pixel and divides by the in-frame count in a chain of divider cells.
// ----------------------------------------------------------------------------
// An item that yields no result returns from ST_CHECK to ST_IDLE before the
// next item is taken. An item that yields a result goes through ST_CHECK, then
// ST_SCAN with one line-store read per in-frame window position, ST_DRAIN,
// ST_LAUNCH, eight divider cells and ST_WAIT, where its result is registered.
// A result waiting at the output holds back the next division and new input.
// Reset (rst_n low, synchronous) loads the register defaults and clears all
// position counters; line-store contents stay undefined and are never read.
module box_mean_filter #(
  parameter int MAX_WIDTH = bmf_pkg::DEF_MAX_WIDTH,
  parameter int MAX_HALF  = bmf_pkg::DEF_MAX_HALF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [bmf_pkg::PIX_W-1:0]        in_red,
  input  logic [bmf_pkg::PIX_W-1:0]        in_green,
  input  logic [bmf_pkg::PIX_W-1:0]        in_blue,
  input  logic                             in_flush,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [bmf_pkg::PIX_W-1:0]        out_red,
  output logic [bmf_pkg::PIX_W-1:0]        out_green,
  output logic [bmf_pkg::PIX_W-1:0]        out_blue,
  output logic                             out_frame_end,
  input  logic                             cfg_we,
  input  logic [bmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bmf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import bmf_pkg::*;

  localparam int CW     = $clog2(MAX_WIDTH);
  localparam int WW     = $clog2(MAX_WIDTH + 1);
  localparam int HW     = $clog2(MAX_HALF + 1);
  localparam int RING   = 2 * MAX_HALF + 2;
  localparam int RW     = $clog2(RING);
  localparam int ROW_W  = FH_W;
  localparam int WIN    = (2 * MAX_HALF + 1) * (2 * MAX_HALF + 1);
  localparam int SUM_W  = $clog2(WIN * 255 + 1);
  localparam int CNT_W  = $clog2(WIN + 1);
  localparam int ADDR_W = RW + CW;
  localparam int PX_W   = NUM_CH * PIX_W;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CHECK, ST_SCAN, ST_DRAIN, ST_LAUNCH, ST_WAIT
  } state_t;

  // Configuration registers.
  logic [FW_W-1:0]   frame_width_r;
  logic [FH_W-1:0]   frame_height_r;
  logic [HALF_W-1:0] row_half_r, col_half_r;

  // Position counters and ring row indexes.
  logic [ROW_W-1:0] in_row_r, out_row_r;
  logic [WW-1:0]    in_col_r, out_col_r;
  logic [RW-1:0]    in_ring_r, out_ring_r;

  state_t state_r;
  logic signed [HW:0] dr_r, dc_r;
  logic [SUM_W-1:0]   sum_r [NUM_CH];
  logic [CNT_W-1:0]   cnt_r;
  logic               rd_pend_r;

  logic             out_valid_r, out_last_r;
  logic [PIX_W-1:0] out_pix_r [NUM_CH];

  // Effective sizes after range limiting.
  logic [WW-1:0]    eff_w;
  logic [ROW_W-1:0] eff_h;
  logic [HW-1:0]    eff_rh, eff_ch;

  always_comb begin
    if (frame_width_r == '0) begin
      eff_w = WW'(1);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width_r);
    end
    eff_h  = (frame_height_r == '0) ? ROW_W'(1) : frame_height_r;
    eff_rh = (32'(row_half_r) > 32'(MAX_HALF)) ? HW'(MAX_HALF) : HW'(row_half_r);
    eff_ch = (32'(col_half_r) > 32'(MAX_HALF)) ? HW'(MAX_HALF) : HW'(col_half_r);
  end

  // Input acceptance and line-store write.
  logic take, wr_en;
  assign in_stall = (state_r != ST_IDLE);
  assign take     = in_valid && !in_stall;
  assign wr_en    = take && !in_flush && (in_row_r < eff_h);

  // Readiness of the next result.
  logic [ROW_W:0] need_r;
  logic [WW:0]    need_c;
  logic           ready;

  always_comb begin
    need_r = (ROW_W+1)'(out_row_r) + (ROW_W+1)'(eff_rh);
    if (need_r > (ROW_W+1)'(eff_h - 1'b1)) begin
      need_r = (ROW_W+1)'(eff_h - 1'b1);
    end
    need_c = (WW+1)'(out_col_r) + (WW+1)'(eff_ch);
    if (need_c > (WW+1)'(eff_w - 1'b1)) begin
      need_c = (WW+1)'(eff_w - 1'b1);
    end
    ready = ((ROW_W+1)'(in_row_r) > need_r) ||
            (((ROW_W+1)'(in_row_r) == need_r) && ((WW+1)'(in_col_r) > need_c));
  end

  // Window position being read.
  logic signed [ROW_W:0] r_s;
  logic signed [WW:0]    c_s;
  logic signed [RW+1:0]  ring_s;
  logic [RW-1:0]         ring_rd;
  logic                  in_frame;

  always_comb begin
    r_s    = $signed({1'b0, out_row_r}) + (ROW_W+1)'(dr_r);
    c_s    = $signed({1'b0, out_col_r}) + (WW+1)'(dc_r);
    ring_s = $signed({2'b0, out_ring_r}) + (RW+2)'(dr_r);
    if (ring_s < 0) begin
      ring_s = ring_s + (RW+2)'(RING);
    end else if (ring_s >= (RW+2)'(RING)) begin
      ring_s = ring_s - (RW+2)'(RING);
    end
    ring_rd  = ring_s[RW-1:0];
    in_frame = (r_s >= 0) && (r_s < $signed({1'b0, eff_h})) &&
               (c_s >= 0) && (c_s < $signed({1'b0, eff_w}));
  end

  // Line store: a ring of rows.
  logic [PX_W-1:0] rd_data;
  logic            rd_en;
  assign rd_en = (state_r == ST_SCAN) && in_frame;

  bmf_ram #(
    .WIDTH(PX_W),
    .DEPTH(RING << CW)
  ) u_line_store (
    .clk  (clk),
    .we   (wr_en),
    .waddr({in_ring_r, in_col_r[CW-1:0]}),
    .wdata({in_red, in_green, in_blue}),
    .re   (rd_en),
    .raddr({ring_rd, c_s[CW-1:0]}),
    .rdata(rd_data)
  );

  // Divider chain: one cell per quotient bit.
  logic             dv_valid [PIX_W+1];
  logic [CNT_W-1:0] dv_den   [PIX_W+1];
  logic [SUM_W-1:0] dv_rem   [PIX_W+1][NUM_CH];
  logic [PIX_W-1:0] dv_quo   [PIX_W+1][NUM_CH];

  always_comb begin
    dv_valid[0] = (state_r == ST_LAUNCH);
    dv_den[0]   = (cnt_r == '0) ? CNT_W'(1) : cnt_r;
    for (int i = 0; i < NUM_CH; i++) begin
      dv_rem[0][i] = sum_r[i];
      dv_quo[0][i] = '0;
    end
  end

  for (genvar k = 0; k < PIX_W; k++) begin : g_div
    bmf_div_cell #(
      .SUM_W(SUM_W),
      .CNT_W(CNT_W),
      .BIT  (PIX_W - 1 - k)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .valid_i(dv_valid[k]),
      .den_i  (dv_den[k]),
      .rem_i  (dv_rem[k]),
      .quo_i  (dv_quo[k]),
      .valid_o(dv_valid[k+1]),
      .den_o  (dv_den[k+1]),
      .rem_o  (dv_rem[k+1]),
      .quo_o  (dv_quo[k+1])
    );
  end

  // Output position after this result.
  logic [WW-1:0]    oc_inc;
  logic [ROW_W-1:0] or_inc;
  logic [RW-1:0]    oring_inc;
  logic             col_wrap, last;

  always_comb begin
    oc_inc    = out_col_r + 1'b1;
    col_wrap  = (oc_inc >= eff_w);
    or_inc    = col_wrap ? out_row_r + 1'b1 : out_row_r;
    oring_inc = out_ring_r;
    if (col_wrap) begin
      oring_inc = (32'(out_ring_r) == RING - 1) ? '0 : out_ring_r + 1'b1;
    end
    last = (or_inc >= eff_h);
  end

  // Control, counters and registered outputs.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      frame_width_r  <= RST_FRAME_WIDTH;
      frame_height_r <= RST_FRAME_HEIGHT;
      row_half_r     <= RST_ROW_HALF;
      col_half_r     <= RST_COL_HALF;
      in_row_r       <= '0;
      in_col_r       <= '0;
      in_ring_r      <= '0;
      out_row_r      <= '0;
      out_col_r      <= '0;
      out_ring_r     <= '0;
      rd_pend_r      <= 1'b0;
      cnt_r          <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      rd_pend_r <= rd_en;
      if (rd_pend_r) begin
        for (int i = 0; i < NUM_CH; i++) begin
          sum_r[i] <= sum_r[i] + SUM_W'(rd_data[PX_W-1-i*PIX_W -: PIX_W]);
        end
        cnt_r <= cnt_r + 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (cfg_we) begin
            case (cfg_index)
              REG_FRAME_WIDTH:  frame_width_r  <= cfg_data[FW_W-1:0];
              REG_FRAME_HEIGHT: frame_height_r <= cfg_data[FH_W-1:0];
              REG_ROW_HALF:     row_half_r     <= cfg_data[HALF_W-1:0];
              REG_COL_HALF:     col_half_r     <= cfg_data[HALF_W-1:0];
              default: ;
            endcase
            if (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT ||
                cfg_index == REG_ROW_HALF || cfg_index == REG_COL_HALF) begin
              in_row_r   <= '0;
              in_col_r   <= '0;
              in_ring_r  <= '0;
              out_row_r  <= '0;
              out_col_r  <= '0;
              out_ring_r <= '0;
            end
          end else if (take) begin
            if (wr_en) begin
              if (in_col_r + 1'b1 >= eff_w) begin
                in_col_r  <= '0;
                in_row_r  <= in_row_r + 1'b1;
                in_ring_r <= (32'(in_ring_r) == RING - 1) ? '0 : in_ring_r + 1'b1;
              end else begin
                in_col_r <= in_col_r + 1'b1;
              end
            end
            state_r <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          if (out_row_r < eff_h && ready) begin
            dr_r  <= -$signed({1'b0, eff_rh});
            dc_r  <= -$signed({1'b0, eff_ch});
            cnt_r <= '0;
            for (int i = 0; i < NUM_CH; i++) begin
              sum_r[i] <= '0;
            end
            state_r <= ST_SCAN;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (dc_r == $signed({1'b0, eff_ch})) begin
            dc_r <= -$signed({1'b0, eff_ch});
            if (dr_r == $signed({1'b0, eff_rh})) begin
              state_r <= ST_DRAIN;
            end else begin
              dr_r <= dr_r + 1'b1;
            end
          end else begin
            dc_r <= dc_r + 1'b1;
          end
        end
        ST_DRAIN: begin
          // The division starts only once the result register is free.
          if (!out_valid_r || !out_stall) begin
            state_r <= ST_LAUNCH;
          end
        end
        ST_LAUNCH: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (dv_valid[PIX_W]) begin
            out_valid_r <= 1'b1;
            out_last_r  <= last;
            out_pix_r   <= dv_quo[PIX_W];
            if (last) begin
              in_row_r   <= '0;
              in_col_r   <= '0;
              in_ring_r  <= '0;
              out_row_r  <= '0;
              out_col_r  <= '0;
              out_ring_r <= '0;
            end else begin
              out_col_r  <= col_wrap ? '0 : oc_inc;
              out_row_r  <= or_inc;
              out_ring_r <= oring_inc;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid     = out_valid_r;
  assign out_red       = out_pix_r[0];
  assign out_green     = out_pix_r[1];
  assign out_blue      = out_pix_r[2];
  assign out_frame_end = out_last_r;

`ifndef SYNTHESIS
  // Results never overtake the input stream.
  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    out_row_r <= in_row_r) else $error("result row ahead of input row");

  // A finished quotient never lands on an unread result.
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    dv_valid[PIX_W] |-> !out_valid_r) else $error("result register overrun");

  // The in-frame count stays within the window size.
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    32'(cnt_r) <= WIN) else $error("window count out of range");

  // A launched division only happens after a complete scan.
  a_launch: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LAUNCH |-> $past(state_r) == ST_DRAIN)
    else $error("division launched without scan");
`endif

endmodule

[src/bmf_ram.sv]
// ----------------------------------------------------------------------------
// bmf_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bmf_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/bmf_div_cell.sv]
// ----------------------------------------------------------------------------
// bmf_div_cell: one cell of the divider chain
// Decides one quotient bit for all three channels and passes the partial
// remainders on to the next cell.
// ----------------------------------------------------------------------------
module bmf_div_cell #(
  parameter int SUM_W = 14,
  parameter int CNT_W = 6,
  parameter int BIT   = 7
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             valid_i,
  input  logic [CNT_W-1:0] den_i,
  input  logic [SUM_W-1:0] rem_i [bmf_pkg::NUM_CH],
  input  logic [bmf_pkg::PIX_W-1:0] quo_i [bmf_pkg::NUM_CH],
  output logic             valid_o,
  output logic [CNT_W-1:0] den_o,
  output logic [SUM_W-1:0] rem_o [bmf_pkg::NUM_CH],
  output logic [bmf_pkg::PIX_W-1:0] quo_o [bmf_pkg::NUM_CH]
);
  import bmf_pkg::*;

  localparam int EXT_W = SUM_W + PIX_W;

  logic [EXT_W-1:0] shifted;
  logic [SUM_W-1:0] rem_nxt [NUM_CH];
  logic [PIX_W-1:0] quo_nxt [NUM_CH];

  // Trial subtraction of the shifted divisor on each channel.
  always_comb begin
    shifted = EXT_W'(den_i) << BIT;
    for (int i = 0; i < NUM_CH; i++) begin
      quo_nxt[i] = quo_i[i];
      rem_nxt[i] = rem_i[i];
      if (EXT_W'(rem_i[i]) >= shifted) begin
        rem_nxt[i]      = SUM_W'(EXT_W'(rem_i[i]) - shifted);
        quo_nxt[i][BIT] = 1'b1;
      end
    end
  end

  // Hand the item on to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= valid_i;
    end
    den_o <= den_i;
    rem_o <= rem_nxt;
    quo_o <= quo_nxt;
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the box mean filter
// Streams RGB frames of many sizes and window half sizes through the filter
// and checks every windowed mean against a behavioural predictor.
// ----------------------------------------------------------------------------
module testbench;
  import bmf_pkg::*;

  localparam int RING      = 2 * DEF_MAX_HALF + 2;
  localparam int SETTLE    = 80;

  typedef struct packed {
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] blue;
    logic             frame_end;
  } mean_pix_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      in_red = '0, in_green = '0, in_blue = '0;
  logic                  in_flush = 1'b0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [PIX_W-1:0]      out_red, out_green, out_blue;
  logic                  out_frame_end;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Predictor state: register copies, line ring and position counters.
  logic [FW_W-1:0]   fr_width  = RST_FRAME_WIDTH;
  logic [FH_W-1:0]   fr_height = RST_FRAME_HEIGHT;
  logic [HALF_W-1:0] win_rh    = RST_ROW_HALF;
  logic [HALF_W-1:0] win_ch    = RST_COL_HALF;
  logic [23:0]       row_ring [RING*DEF_MAX_WIDTH];
  int unsigned       px_row = 0, px_col = 0, res_row = 0, res_col = 0;

  mean_pix_t expected_means[$];
  int        errors = 0;
  int        pixels_sent = 0;
  int        gap_next = 0;
  bit        burst = 1'b0;
  bit        hold_req = 1'b0;

  always #6 clk = ~clk;

  box_mean_filter u_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_red, .in_green, .in_blue, .in_flush,
    .out_valid, .out_stall, .out_red, .out_green, .out_blue, .out_frame_end,
    .cfg_we, .cfg_index, .cfg_data
  );

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, 19);
  endfunction

  function automatic bit frame_idle();
    return px_row == 0 && px_col == 0 && res_row == 0 && res_col == 0;
  endfunction

  // Window mean predictor: takes one accepted item, may queue one mean.
  function automatic void predict_mean(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                       logic fl);
    int unsigned w, h, rh, ch, need_r, need_c, sr, sg, sb, cnt;
    int          rr, cc;
    logic [23:0] px;
    mean_pix_t   m;
    w  = (fr_width == 0) ? 1 : (fr_width > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : fr_width);
    h  = (fr_height == 0) ? 1 : fr_height;
    rh = (win_rh > DEF_MAX_HALF) ? DEF_MAX_HALF : win_rh;
    ch = (win_ch > DEF_MAX_HALF) ? DEF_MAX_HALF : win_ch;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    if (!fl && px_row < h) begin
      row_ring[(px_row % RING) * DEF_MAX_WIDTH + px_col] = {r, g, b};
      px_col++;
      if (px_col >= w) begin
        px_col = 0;
        px_row++;
      end
    end
    if (res_row >= h) return;
    need_r = (res_row + rh < h - 1) ? res_row + rh : h - 1;
    need_c = (res_col + ch < w - 1) ? res_col + ch : w - 1;
    if (!(px_row > need_r || (px_row == need_r && px_col > need_c))) return;
    for (rr = int'(res_row) - int'(rh); rr <= int'(res_row) + int'(rh); rr++) begin
      if (rr < 0 || rr >= int'(h)) continue;
      for (cc = int'(res_col) - int'(ch); cc <= int'(res_col) + int'(ch); cc++) begin
        if (cc < 0 || cc >= int'(w)) continue;
        px = row_ring[(rr % RING) * DEF_MAX_WIDTH + cc];
        sr += px[23:16];
        sg += px[15:8];
        sb += px[7:0];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    res_col++;
    if (res_col >= w) begin
      res_col = 0;
      res_row++;
    end
    m.red = 8'(sr / cnt);
    m.green = 8'(sg / cnt);
    m.blue = 8'(sb / cnt);
    m.frame_end = (res_row >= h);
    if (m.frame_end) begin
      px_row = 0; px_col = 0; res_row = 0; res_col = 0;
    end
    expected_means.push_back(m);
  endfunction

  // Offer one item and hold it until it is accepted.
  task automatic send_item(logic [7:0] r, logic [7:0] g, logic [7:0] b, logic fl);
    if (gap_next > 0) repeat (gap_next) @(posedge clk);
    in_valid <= 1'b1;
    in_red <= r; in_green <= g; in_blue <= b; in_flush <= fl;
    do @(posedge clk); while (in_stall);
    predict_mean(r, g, b, fl);
    if (!fl) pixels_sent++;
    gap_next = draw_gap();
    if (gap_next > 0) in_valid <= 1'b0;
  endtask

  task automatic stop_items();
    if (gap_next == 0) in_valid <= 1'b0;
    gap_next = 1;
    @(posedge clk);
    gap_next = draw_gap();
  endtask

  task automatic wait_idle();
    stop_items();
    while (expected_means.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH:  fr_width  = val[FW_W-1:0];
      REG_FRAME_HEIGHT: fr_height = val[FH_W-1:0];
      REG_ROW_HALF:     win_rh    = val[HALF_W-1:0];
      REG_COL_HALF:     win_ch    = val[HALF_W-1:0];
      default: ;
    endcase
    if (idx <= REG_COL_HALF) begin
      px_row = 0; px_col = 0; res_row = 0; res_col = 0;
    end
    @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, int rh, int ch);
    write_reg(REG_FRAME_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_FRAME_HEIGHT, CFG_DATA_W'(h));
    write_reg(REG_ROW_HALF, CFG_DATA_W'(rh));
    write_reg(REG_COL_HALF, CFG_DATA_W'(ch));
  endtask

  // One whole frame: npix pixels, then drain items until the frame closes.
  // Mid-frame flushes are scattered in with the given percentage.
  task automatic run_frame(int npix, int flush_pct);
    int k;
    k = 0;
    while (k < npix) begin
      if ($urandom_range(0, 99) < flush_pct) begin
        send_item($urandom, $urandom, $urandom, 1'b1);
      end else begin
        send_item($urandom, $urandom, $urandom, 1'b0);
        k++;
      end
    end
    // Drain with a mix of flushes and surplus pixels, which act as flushes.
    while (!frame_idle())
      send_item($urandom, $urandom, $urandom, $urandom_range(0, 1));
  endtask

  // Windows of 0 and 255, identity window, a single pixel frame.
  task automatic test_extremes();
    set_frame(3, 3, 1, 1);
    for (int i = 0; i < 9; i++)
      send_item(i[0] ? 8'hFF : 8'h00, i[0] ? 8'h00 : 8'hFF, 8'hFF, 1'b0);
    send_item(8'h00, 8'h00, 8'h00, 1'b1);
    while (!frame_idle()) send_item(8'h12, 8'h34, 8'h56, 1'b1);
    set_frame(2, 2, 0, 0);
    run_frame(4, 0);
    set_frame(1, 1, 3, 3);
    run_frame(1, 0);
  endtask

  // Width and height of zero act as one; oversized width saturates.
  task automatic test_size_limits();
    set_frame(0, 0, 2, 1);
    run_frame(1, 0);
    set_frame(13'h1FFF, 1, 3, 3);
    run_frame(DEF_MAX_WIDTH, 2);
    set_frame(1, 300, 3, 3);
    run_frame(300, 0);
  endtask

  // Flushes mid-frame, a frame aborted by a register write, unused index.
  task automatic test_flush_abort();
    set_frame(5, 4, 2, 3);
    run_frame(20, 30);
    for (int i = 0; i < 9; i++) send_item($urandom, $urandom, $urandom, 1'b0);
    write_reg(REG_ROW_HALF, 13'd1);
    write_reg(3'd5, 13'h1FFF);
    run_frame(20, 0);
  endtask

  // Receiver holds off for a long stretch while one frame is sent in a burst.
  task automatic test_backpressure();
    set_frame(8, 6, 2, 2);
    burst = 1'b1;
    gap_next = 0;
    hold_req = 1'b1;
    run_frame(48, 0);
    burst = 1'b0;
  endtask

  // Random frames, mostly small, with occasional aborts.
  task automatic test_random_frames();
    int w, h;
    while (pixels_sent < 2000) begin
      burst = ($urandom_range(0, 3) == 0);
      w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(1, 12);
      h = $urandom_range(0, 10);
      set_frame(w, h, $urandom_range(0, 3), $urandom_range(0, 3));
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(1, 10)) send_item($urandom, $urandom, $urandom, 1'b0);
        write_reg(REG_COL_HALF, CFG_DATA_W'($urandom_range(0, 3)));
      end
      run_frame((w == 0 ? 1 : w) * (h == 0 ? 1 : h), $urandom_range(0, 1) ? 0 : 10);
    end
    burst = 1'b0;
  endtask

  // Result side stall pattern, with an optional long hold-off.
  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        n = draw_gap();
        if (n > 0) begin
          out_stall <= 1'b1;
          repeat (n) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Compare each accepted mean with the oldest expectation.
  always @(posedge clk) begin
    mean_pix_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_means.size() == 0) begin
        $error("unexpected result red=%0d green=%0d blue=%0d", out_red, out_green,
               out_blue);
        errors++;
      end else begin
        e = expected_means.pop_front();
        if (out_red !== e.red) begin
          $error("red_out expected %0d got %0d", e.red, out_red);
          errors++;
        end
        if (out_green !== e.green) begin
          $error("green_out expected %0d got %0d", e.green, out_green);
          errors++;
        end
        if (out_blue !== e.blue) begin
          $error("blue_out expected %0d got %0d", e.blue, out_blue);
          errors++;
        end
        if (out_frame_end !== e.frame_end) begin
          $error("frame_end expected %0d got %0d", e.frame_end, out_frame_end);
          errors++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    gap_next = draw_gap();
    test_extremes();
    test_size_limits();
    test_flush_abort();
    test_backpressure();
    test_random_frames();
    wait_idle();
    if (expected_means.size() != 0) errors++;
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Run limit.
  initial begin
    #60_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
